### src/b2d_pkg.sv
package b2d_pkg;

  // Width of the input port and of the part that is converted
  localparam int VALUE_W    = 64;
  localparam int VALUE_BITS = 64;

  // Decimal digits needed for VALUE_BITS bits (floor(bits * log10(2)) + 1)
  localparam int DIGITS = (VALUE_BITS * 30103) / 100000 + 1;

  localparam int CNT_W  = $clog2(VALUE_BITS);
  localparam int REM_W  = $clog2(DIGITS + 1);
  localparam int BCD_W  = 4;
  localparam int CHAR_W = 6;

  // ASCII '0' in the 6-bit character field
  localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

  // Control broadcast to every digit cell
  typedef struct packed {
    logic clear;   // zero the digit at item start
    logic dabble;  // add-3 correction and shift one binary bit in
    logic move;    // take the digit of the lower neighbor
  } b2d_ctl_t;

endpackage

### src/b2d_cell.sv
module b2d_cell (
  input  logic                     clk,
  input  b2d_pkg::b2d_ctl_t        ctl,
  input  logic                     bit_in,
  input  logic [b2d_pkg::BCD_W-1:0] digit_in,
  output logic                     bit_out,
  output logic [b2d_pkg::BCD_W-1:0] digit
);
  import b2d_pkg::*;

  logic [BCD_W-1:0] adj;

  // Add 3 to digits of five or more so the shift carries into the next decade
  always_comb begin
    adj     = (digit >= 4'd5) ? (digit + 4'd3) : digit;
    bit_out = adj[BCD_W-1];
  end

  // Clear, shift one bit in, or take the neighbor's digit
  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      digit <= '0;
    end else if (ctl.dabble) begin
      digit <= {adj[BCD_W-2:0], bit_in};
    end else if (ctl.move) begin
      digit <= digit_in;
    end
  end

endmodule

### src/binary_to_decimal_ascii.sv
// Accepts a value and shifts its VALUE_BITS (64) bits MSB first through the digit row with
// shift-add-3, then shifts the row out one decade per cycle, top digit first, unless the
// output stalls; leading zeros are dropped but each still takes a shift step. A new item is
// taken only after the last digit of the previous one has been emitted.
// Reset (rst, synchronous) returns to idle, empties the output register and holds in_stall.
module binary_to_decimal_ascii (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [b2d_pkg::VALUE_W-1:0]   value,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [b2d_pkg::CHAR_W-1:0]    digit_char,
  output logic                          last
);
  import b2d_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CONV = 2'd1;
  localparam logic [1:0] S_EMIT = 2'd2;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [VALUE_BITS-1:0] shreg;
  logic [CNT_W-1:0]      bit_cnt;
  logic [REM_W-1:0]      rem;
  logic                  seen;

  logic                  accept;
  logic                  out_free;
  logic                  emit_take;
  logic                  skip;
  logic [BCD_W-1:0]      top_digit;
  b2d_ctl_t              ctl;

  logic [BCD_W-1:0]      digit    [DIGITS];
  logic                  bit_link [DIGITS];

  // Row of BCD digit cells, least significant at index zero
  for (genvar i = 0; i < DIGITS; i++) begin : g_cell
    if (i == 0) begin : g_first
      b2d_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .bit_in   (shreg[VALUE_BITS-1]),
        .digit_in ({BCD_W{1'b0}}),
        .bit_out  (bit_link[i]),
        .digit    (digit[i])
      );
    end else begin : g_rest
      b2d_cell u_cell (
        .clk      (clk),
        .ctl      (ctl),
        .bit_in   (bit_link[i-1]),
        .digit_in (digit[i-1]),
        .bit_out  (bit_link[i]),
        .digit    (digit[i])
      );
    end
  end

  // Handshake and emit decisions
  always_comb begin
    accept    = in_valid && !in_stall;
    out_free  = !out_valid || !out_stall;
    top_digit = digit[DIGITS-1];
    skip      = (state == S_EMIT) && (top_digit == '0) && !seen && (rem != REM_W'(1));
    emit_take = (state == S_EMIT) && !skip && out_free;
    ctl.clear  = accept;
    ctl.dabble = (state == S_CONV);
    ctl.move   = emit_take || skip;
  end

  // Refuse items during reset and while a conversion is in flight
  assign in_stall = rst || (state != S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) state_next = S_CONV;
      end
      S_CONV: begin
        if (bit_cnt == '0) state_next = S_EMIT;
      end
      S_EMIT: begin
        if (emit_take && (rem == REM_W'(1))) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Sequencer counters and state
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      bit_cnt <= '0;
      rem     <= '0;
      seen    <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        S_IDLE: begin
          if (accept) bit_cnt <= CNT_W'(VALUE_BITS - 1);
        end
        S_CONV: begin
          bit_cnt <= bit_cnt - 1'b1;
          if (bit_cnt == '0) begin
            rem  <= REM_W'(DIGITS);
            seen <= 1'b0;
          end
        end
        S_EMIT: begin
          if (ctl.move)  rem  <= rem - 1'b1;
          if (emit_take) seen <= 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Load the value, then shift it out MSB first into the row
  always_ff @(posedge clk) begin
    if (accept) begin
      shreg <= value[VALUE_BITS-1:0];
    end else if (state == S_CONV) begin
      shreg <= {shreg[VALUE_BITS-2:0], 1'b0};
    end
  end

  // Output register: hold while stalled, drop once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit_take) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_take) begin
      digit_char <= ASCII_ZERO + {{(CHAR_W-BCD_W){1'b0}}, top_digit};
      last       <= (rem == REM_W'(1));
    end
  end

endmodule

### bench/tb_binary_to_decimal_ascii.sv
module tb_binary_to_decimal_ascii;
  timeunit 1ns;
  timeprecision 1ps;

  import b2d_pkg::*;

  localparam int RANDOM_ITEMS = 250;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 120;

  // One expected decimal digit, tagged with the value that produced it
  typedef struct {
    logic [CHAR_W-1:0]  digit_char;
    logic               last;
    logic [VALUE_W-1:0] source;
  } digit_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [VALUE_W-1:0]  value = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [CHAR_W-1:0]   digit_char;
  logic                last;

  logic [VALUE_W-1:0]  pending_values[$];
  digit_t              expected_digits[$];
  logic                in_taken = 1'b0;
  int                  burst_left = 0;
  int                  gap_left = 0;
  int                  stall_tick = 0;
  int                  cycles = 0;
  int                  errors = 0;

  binary_to_decimal_ascii u_top (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .value      (value),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .digit_char (digit_char),
    .last       (last)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [VALUE_W-1:0] source,
                                 input logic [VALUE_W-1:0] got,
                                 input logic [VALUE_W-1:0] want);
    $display("[%0t] mismatch on %s for value %0d: got %0d, expected %0d",
             $realtime, what, source, got, want);
    errors++;
  endtask

  // Queue the decimal digits of a value, most significant first
  task automatic push_decimal_digits(input logic [VALUE_W-1:0] raw);
    logic [VALUE_W-1:0] mask;
    logic [VALUE_W-1:0] v;
    logic [3:0]         rev[$];
    digit_t             d;
    int                 k;
    mask = (VALUE_BITS >= VALUE_W) ? '1 : ((VALUE_W'(1) << VALUE_BITS) - 1);
    v = raw & mask;
    do begin
      rev.push_back(4'(v % 10));
      v = v / 10;
    end while (v != 0);
    for (k = rev.size() - 1; k >= 0; k--) begin
      d.digit_char = CHAR_W'(ASCII_ZERO + rev[k]);
      d.last       = (k == 0);
      d.source     = raw;
      expected_digits.push_back(d);
    end
  endtask

  // Drive items in bursts with random gaps; hold the payload while stalled
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_valid <= 1'b0;
      end else if (pending_values.size() != 0) begin
        in_valid <= 1'b1;
        value    <= pending_values.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 8);
          gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Stall the output on a shifting pattern: free, random, periodic runs, sparse
  always @(negedge clk) begin
    stall_tick <= stall_tick + 1;
    case ((stall_tick >> 9) % 4)
      0: begin
        out_stall <= 1'b0;
      end
      1: begin
        out_stall <= ($urandom_range(0, 1) == 1);
      end
      2: begin
        out_stall <= (((stall_tick >> 2) % 8) == 5);
      end
      default: begin
        out_stall <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // Predict on every accepted item and check every accepted digit
  always @(posedge clk) begin
    digit_t exp_d;
    if (rst) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_valid && !in_stall;
      if (in_valid && !in_stall)
        push_decimal_digits(value);
      if (out_valid && !out_stall) begin
        if (expected_digits.size() == 0) begin
          report_mismatch("unexpected digit", '0, VALUE_W'(digit_char), '0);
        end else begin
          exp_d = expected_digits.pop_front();
          if (digit_char !== exp_d.digit_char)
            report_mismatch("digit_char", exp_d.source, VALUE_W'(digit_char),
                            VALUE_W'(exp_d.digit_char));
          if (last !== exp_d.last)
            report_mismatch("last", exp_d.source, VALUE_W'(last), VALUE_W'(exp_d.last));
        end
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [VALUE_W-1:0] r;
    logic [VALUE_W-1:0] p;
    int                 n;
    int                 k;

    // Corner values: zero, digit boundaries, full width, bit patterns
    pending_values.push_back(64'd0);
    pending_values.push_back(64'd1);
    pending_values.push_back(64'd9);
    pending_values.push_back(64'd10);
    pending_values.push_back(64'd11);
    pending_values.push_back(64'd99);
    pending_values.push_back(64'd100);
    pending_values.push_back(64'd999999999);
    pending_values.push_back(64'd4294967295);
    pending_values.push_back(64'd4294967296);
    pending_values.push_back(64'd1234567890123456789);
    pending_values.push_back(64'd9999999999999999999);
    pending_values.push_back(64'd10000000000000000000);
    pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'h8000_0000_0000_0000);
    pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFE);
    pending_values.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'h5555_5555_5555_5555);
    pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_values.push_back(64'd100000000000000000);

    // Random values of every magnitude, many near powers of ten
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      r = {$urandom(), $urandom()};
      case ($urandom_range(0, 3))
        0: begin
        end
        1: begin
          r = r >> $urandom_range(0, 63);
        end
        2: begin
          p = 64'd1;
          for (k = $urandom_range(0, 19); k > 0; k--)
            p = p * 10;
          r = p + VALUE_W'($urandom_range(0, 2)) - VALUE_W'(1);
        end
        default: begin
          r = VALUE_W'($urandom_range(0, 999));
        end
      endcase
      pending_values.push_back(r);
    end

    // Hold reset, then release at a falling edge
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for all items to go in and all digits to come out
    @(negedge clk);
    while (pending_values.size() != 0 || in_valid || expected_digits.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (expected_digits.size() != 0)
      errors++;
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
